/* rtl/literal_resolution_merge_top_defines.svh */
// assertion macros for the literal resolution merge block
`ifndef LITERAL_RESOLUTION_MERGE_TOP_DEFINES_SVH
`define LITERAL_RESOLUTION_MERGE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define LRM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define LRM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lrm_pkg.sv */
// shared constants and controller/datapath interface types for the literal merge
package lrm_pkg;

   localparam int MAX_VARS_DEF  = 16384;
   localparam int WORD_BITS_DEF = 512;

   localparam int MODE_W  = 2;
   localparam int KIND_W  = 2;
   localparam int LIT_W   = 16;
   localparam int NET_W   = 15;
   localparam int SEEN_W  = 64;
   localparam int CSR_W   = 6;

   localparam logic [CSR_W-1:0]  CLEAR_WORDS_RST = 6'd32;
   localparam logic [1:0]        BOTH_POLARITIES = 2'b11;
   localparam logic [1:0]        POL_POS         = 2'b01;
   localparam logic [1:0]        POL_NEG         = 2'b10;

   localparam logic [MODE_W-1:0] MODE_LITERAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_END     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COUNT   = 2'd2;

   typedef struct packed {
      logic lookup;
      logic commit;
      logic emit_end;
      logic emit_count;
      logic clear_start;
      logic sweep_step;
   } cmd_type;

   typedef struct packed {
      logic lit_ok;
      logic lit_emit;
      logic out_free;
      logic sweep_done;
   } stat_type;

endpackage

/* rtl/lrm_ctrl.sv */
// sequencing state machine for the literal merge
module lrm_ctrl
   import lrm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   input  stat_type          stat,
   output logic              req_ready,
   output cmd_type           cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_END_MARK,
      ST_END_COUNT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      accept;

   assign accept    = req_valid && ready_ff;
   assign req_ready = ready_ff;
   assign ready_in  = (state_in == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_LITERAL: begin
                     if (stat.lit_ok) begin
                        cmd.lookup = 1'b1;
                        state_in   = ST_UPDATE;
                     end
                  end
                  MODE_END: begin
                     state_in = ST_END_MARK;
                  end
                  MODE_CLEAR: begin
                     cmd.clear_start = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_UPDATE: begin
            if (!stat.lit_emit || stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_END_MARK: begin
            if (stat.out_free) begin
               cmd.emit_end = 1'b1;
               state_in     = ST_END_COUNT;
            end
         end
         ST_END_COUNT: begin
            if (stat.out_free) begin
               cmd.emit_count = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (stat.sweep_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.sweep_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule

/* rtl/lrm_datapath.sv */
// status and validity memories, counters and output register of the literal merge
module lrm_datapath
   import lrm_pkg::*;
#(
   parameter int MAX_VARS  = MAX_VARS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [LIT_W-1:0]  req_literal,
   input  logic                     csr_wr_en,
   input  logic [CSR_W-1:0]         csr_wr_data,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [KIND_W-1:0]        rsp_out_kind,
   output logic signed [LIT_W-1:0]  rsp_out_literal,
   output logic signed [LIT_W-1:0]  rsp_out_count,
   output logic [SEEN_W-1:0]        rsp_out_seen,
   output logic                     rsp_last
);

   localparam int IDX_W     = $clog2(MAX_VARS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int NUM_WORDS = MAX_VARS / WORD_BITS;
   localparam int ROW_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int SWP_W     = $clog2(NUM_WORDS + 1);

   // memories
   logic [1:0]           status_mem [MAX_VARS];
   logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];

   // lookup address from the incoming literal
   logic [LIT_W-1:0] raw_c;
   logic [LIT_W-1:0] idx16_c;
   logic [31:0]      idx_wide_c;
   logic [31:0]      row_wide_c;
   logic [IDX_W-1:0] addr_c;
   logic [ROW_W-1:0] row_c;
   logic [BIT_W-1:0] bit_c;

   // registered lookup
   logic [IDX_W-1:0]        addr_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [BIT_W-1:0]        bit_ff;
   logic                    neg_ff;
   logic [LIT_W-1:0]        raw_ff;
   logic [1:0]              status_rd_ff;
   logic [WORD_BITS-1:0]    word_rd_ff;

   // update
   logic [1:0]           old_status;
   logic [1:0]           pol_bit;
   logic [1:0]           new_status;
   logic                 insert;
   logic                 both;
   logic [WORD_BITS-1:0] set_word;

   // state registers
   logic [CSR_W-1:0]  clear_words_ff;
   logic [NET_W-1:0]  net_ff, net_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [SWP_W-1:0]  sweep_row_ff, sweep_end_ff;
   logic [31:0]       sweep_wide;
   logic [31:0]       clear_n_wide;

   // output register
   logic                    out_valid_ff;
   logic [KIND_W-1:0]       out_kind_ff;
   logic [LIT_W-1:0]        out_literal_ff;
   logic [LIT_W-1:0]        out_count_ff;
   logic [SEEN_W-1:0]       out_seen_ff;
   logic                    out_last_ff;

   // magnitude minus one: ~raw for negatives, raw - 1 otherwise
   assign raw_c      = req_literal;
   assign idx16_c    = raw_c[LIT_W-1] ? ~raw_c : (raw_c - LIT_W'(1));
   assign idx_wide_c = 32'(idx16_c);
   assign row_wide_c = idx_wide_c >> BIT_W;
   assign addr_c     = idx_wide_c[IDX_W-1:0];
   assign row_c      = row_wide_c[ROW_W-1:0];
   assign bit_c      = idx_wide_c[BIT_W-1:0];

   assign old_status = word_rd_ff[bit_ff] ? status_rd_ff : 2'b00;
   assign pol_bit    = neg_ff ? POL_NEG : POL_POS;
   assign insert     = ((old_status & pol_bit) == 2'b00);
   assign new_status = old_status | pol_bit;
   assign both       = (new_status == BOTH_POLARITIES);
   assign set_word   = word_rd_ff | (WORD_BITS'(1) << bit_ff);

   assign sweep_wide   = 32'(sweep_row_ff);
   assign clear_n_wide = (32'(clear_words_ff) > 32'(NUM_WORDS)) ? 32'(NUM_WORDS)
                                                                : 32'(clear_words_ff);

   assign seen_in = seen_ff + SEEN_W'(1);

   always_comb begin
      net_in = net_ff;
      if (cmd.commit) begin
         if (both) begin
            net_in = net_ff - NET_W'(1);
         end else if (insert) begin
            net_in = net_ff + NET_W'(1);
         end
      end else if (cmd.emit_count) begin
         net_in = '0;
      end
   end

   always_comb begin
      stat.lit_ok     = (raw_c != '0) && (idx_wide_c < 32'(MAX_VARS));
      stat.lit_emit   = insert && !both;
      stat.out_free   = !out_valid_ff || rsp_ready;
      stat.sweep_done = (sweep_row_ff == sweep_end_ff);
   end

   // memory reads
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         status_rd_ff <= status_mem[addr_c];
         word_rd_ff   <= bitmap_mem[row_c];
         addr_ff      <= addr_c;
         row_ff       <= row_c;
         bit_ff       <= bit_c;
         neg_ff       <= raw_c[LIT_W-1];
         raw_ff       <= raw_c;
      end
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (cmd.commit && stat.lit_emit) begin
         status_mem[addr_ff] <= new_status;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         bitmap_mem[row_ff] <= set_word;
      end else if (cmd.sweep_step) begin
         bitmap_mem[sweep_wide[ROW_W-1:0]] <= '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_words_ff <= CLEAR_WORDS_RST;
         net_ff         <= '0;
         seen_ff        <= '0;
         sweep_row_ff   <= '0;
         sweep_end_ff   <= SWP_W'(NUM_WORDS);
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            clear_words_ff <= csr_wr_data;
         end
         net_ff <= net_in;
         if (cmd.commit) begin
            seen_ff <= seen_in;
         end
         if (cmd.clear_start) begin
            sweep_row_ff <= '0;
            sweep_end_ff <= clear_n_wide[SWP_W-1:0];
         end else if (cmd.sweep_step) begin
            sweep_row_ff <= sweep_row_ff + SWP_W'(1);
         end
         if ((cmd.commit && stat.lit_emit) || cmd.emit_end || cmd.emit_count) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (cmd.commit && stat.lit_emit) begin
         out_kind_ff    <= KIND_LITERAL;
         out_literal_ff <= raw_ff;
         out_count_ff   <= '0;
         out_seen_ff    <= seen_in;
         out_last_ff    <= 1'b1;
      end else if (cmd.emit_end) begin
         out_kind_ff    <= KIND_END;
         out_literal_ff <= '0;
         out_count_ff   <= '0;
         out_seen_ff    <= seen_ff;
         out_last_ff    <= 1'b0;
      end else if (cmd.emit_count) begin
         out_kind_ff    <= KIND_COUNT;
         out_literal_ff <= '0;
         out_count_ff   <= {net_ff[NET_W-1], net_ff};
         out_seen_ff    <= seen_ff;
         out_last_ff    <= 1'b1;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_kind    = out_kind_ff;
   assign rsp_out_literal = out_literal_ff;
   assign rsp_out_count   = out_count_ff;
   assign rsp_out_seen    = out_seen_ff;
   assign rsp_last        = out_last_ff;

endmodule

/* rtl/literal_resolution_merge_top.sv */
// top level of the literal resolution merge block
//
// req channel (valid/ready) carries one item per transfer: a literal, an end of
// clause stream, or a clear of the validity bitmap. rsp channel (valid/ready)
// carries kept literals, the end marker and the signed element count.
// csr_wr_en/csr_wr_data write clear_words at once; the user must write it only while
// the block is idle, which the block does not enforce. a literal is accepted with the
// status and bitmap memory reads, then read-modify-written in the update state, which
// loads a kept literal into the output register; no new item is taken until that
// write is done. an end item emits the marker, then the count with last set; the
// count is zeroed. a clear item zeroes n = min(clear_words, words) bitmap words, one
// word a cycle. after reset all MAX_VARS / WORD_BITS bitmap words (32 by default) are
// swept once, one word a cycle, and req_ready stays low until that pass is done;
// status entries are never cleared and are used only while their validity bit is set.
// when the receiver stalls, the result waits in the output register; the block
// still takes the next item, and holds in its emit cycle only when a new result
// finds the output register full.
`include "literal_resolution_merge_top_defines.svh"

module literal_resolution_merge_top
   import lrm_pkg::*;
#(
   parameter int MAX_VARS  = MAX_VARS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // input items
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic signed [LIT_W-1:0]  req_literal,
   // result items
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [KIND_W-1:0]        rsp_out_kind,
   output logic signed [LIT_W-1:0]  rsp_out_literal,
   output logic signed [LIT_W-1:0]  rsp_out_count,
   output logic [SEEN_W-1:0]        rsp_out_seen,
   output logic                     rsp_last,
   // configuration
   input  logic                     csr_wr_en,
   input  logic [CSR_W-1:0]         csr_wr_data
);

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   lrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   lrm_datapath #(
      .MAX_VARS  (MAX_VARS),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_literal     (req_literal),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_literal (rsp_out_literal),
      .rsp_out_count   (rsp_out_count),
      .rsp_out_seen    (rsp_out_seen),
      .rsp_last        (rsp_last)
   );

   // checks

   // the count result directly follows the transfer of an end marker
   `LRM_ASSERT_NEXT(a_count_follows_end, rsp_valid && rsp_ready && (rsp_out_kind == KIND_END), rsp_valid && (rsp_out_kind == KIND_COUNT), "count result does not follow end marker")

   // results are only loaded when the output register can take them
   `LRM_ASSERT_NOW(a_load_when_free, cmd.emit_end || cmd.emit_count || (cmd.commit && stat.lit_emit), stat.out_free, "result loaded into a full output register")

   // no item is taken before a bitmap sweep has finished
   `LRM_ASSERT_NOW(a_ready_after_sweep, req_ready, stat.sweep_done, "input ready during bitmap sweep")

   // a kept literal is never zero
   `LRM_ASSERT_NOW(a_literal_nonzero, rsp_valid && (rsp_out_kind == KIND_LITERAL), rsp_out_literal != '0, "zero literal passed on")

endmodule
